// File: sv/pfx_pkg.sv
// Shared constants, codes and control structs for the postfix evaluator.
package pfx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_DIGITS = 2'd1;
  localparam logic [1:0] MODE_OPER   = 2'd2;
  localparam logic [1:0] MODE_TAIL   = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_COUNT  = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_BADNUM = 3'd4;
  localparam logic [2:0] ST_OVER   = 3'd5;

  typedef struct packed {
    logic capture;    // latch an accepted character
    logic take;       // apply the character to the token state
    logic finish;     // close a number token (push) or an empty token
    logic op_fail;    // operator without two operands, or after an earlier error
    logic op_read;    // fetch the lower operand from the stack memory
    logic op_arith;   // write back an add, subtract or multiply
    logic op_divz;    // flag divide by zero
    logic div_start;  // launch the divider
    logic div_write;  // write back the quotient
    logic emit;       // load the result register and clear the stack
  } cmd_t;

  typedef struct packed {
    logic last;
    logic space;
    logic mode_oper;
    logic op_ok;
    logic op_div;
    logic b_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: sv/postfix_expression_evaluator_top.sv
// Postfix integer expression evaluator: top level joining sequencer and datapath.
// Characters of a postfix expression enter one per transaction, the last one
// flagged by end_of_expr; one result (value, status) leaves after the last one.
// An ordinary character is captured, then applied to the token state. A space
// or the last character adds the token finish: a push for a number; for + - *
// the lower operand is read from the 16-entry stack memory, whose read data is
// registered, while the top of stack sits in a register; and for / a radix-2
// divider takes one quotient bit per cycle plus a sign fix-up. The last
// character loads the result register and waits there while an earlier result
// is still held by out_stall. Status codes: 0 ok, 1 not exactly one value left,
// 2 underflow, 3 divide by zero, 4 bad number, 5 stack overflow; value is zero
// whenever status is not ok, and the first error of an expression is kept.
module postfix_expression_evaluator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        char_in,
  input  logic                              end_of_expr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pfx_pkg::DATA_W-1:0] value,
  output logic [2:0]                        status
);

  pfx_pkg::cmd_t  cmd;
  pfx_pkg::stat_t stat;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfx_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .char_in     (char_in),
    .end_of_expr (end_of_expr),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .value       (value),
    .status      (status)
  );

endmodule

// File: sv/pfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pfx_div.sv
// Radix-2 restoring signed divider, truncating toward zero.
module pfx_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfx_pkg::DATA_W-1:0] dividend,
  input  logic [pfx_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pfx_pkg::DATA_W-1:0] quotient
);

  localparam int W   = pfx_pkg::DATA_W;
  localparam int CNT = $clog2(W);

  logic           active;
  logic           fix;
  logic [CNT-1:0] cnt;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [W-1:0]   dvs;
  logic           neg;
  logic [W:0]     rem_sh;
  logic [W:0]     diff;

  assign rem_sh   = {rem, quo[W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      fix    <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        fix    <= 1'b0;
      end else if (active && cnt == CNT'(W - 1)) begin
        active <= 1'b0;
        fix    <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[W-1] ? W'(-dividend) : dividend;
      dvs <= divisor[W-1] ? W'(-divisor) : divisor;
      neg <= dividend[W-1] ^ divisor[W-1];
      rem <= '0;
      cnt <= '0;
    end else if (active) begin
      cnt <= cnt + CNT'(1);
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end else if (fix && neg) begin
      // magnitude back to signed; the most negative value wraps onto itself
      quo <= W'(-quo);
    end
  end

endmodule

// File: sv/pfx_datapath.sv
// Token state, operand stack, arithmetic and result register.
module pfx_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pfx_pkg::cmd_t               cmd,
  output pfx_pkg::stat_t              stat,
  input  logic [7:0]                  char_in,
  input  logic                        end_of_expr,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic signed [pfx_pkg::DATA_W-1:0] value,
  output logic [2:0]                  status
);

  localparam int W  = pfx_pkg::DATA_W;
  localparam int AW = pfx_pkg::STACK_AW;
  localparam int CW = pfx_pkg::STACK_CW;

  logic [7:0]    ch;
  logic          last;
  logic [1:0]    mode;
  logic [W-1:0]  acc;
  logic [1:0]    op;
  logic [2:0]    err;
  logic [CW-1:0] count;
  logic [W-1:0]  tos;

  logic          is_space;
  logic          is_digit;
  logic [W-1:0]  digit_val;
  logic [W-1:0]  acc_next;
  logic [CW-1:0] below;
  logic [W-1:0]  opnd_a;
  logic [W-1:0]  arith_res;
  logic [W-1:0]  wb_res;
  logic          div_done;
  logic [W-1:0]  div_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic          ram_re;
  logic          push_ok;
  logic [2:0]    st_final;

  assign is_space  = (ch == pfx_pkg::CH_SPACE);
  assign is_digit  = (ch >= pfx_pkg::CH_ZERO) && (ch <= pfx_pkg::CH_NINE);
  assign digit_val = W'(ch - pfx_pkg::CH_ZERO);
  assign acc_next  = (acc << 3) + (acc << 1) + digit_val;
  assign below     = count - CW'(2);
  assign push_ok   = (count != CW'(pfx_pkg::STACK_DEPTH));

  always_comb begin
    case (op)
      pfx_pkg::OP_ADD: arith_res = opnd_a + tos;
      pfx_pkg::OP_SUB: arith_res = opnd_a - tos;
      pfx_pkg::OP_MUL: arith_res = opnd_a * tos;
      default:         arith_res = div_q;
    endcase
  end

  assign wb_res = cmd.div_write ? div_q : arith_res;

  // push writes at the count, a finished operator overwrites the lower operand
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = acc;
    if (cmd.finish && (mode == pfx_pkg::MODE_DIGITS || mode == pfx_pkg::MODE_TAIL) &&
        err == pfx_pkg::ST_OK && push_ok) begin
      ram_we = 1'b1;
    end else if (cmd.op_arith || cmd.div_write) begin
      ram_we    = 1'b1;
      ram_waddr = below[AW-1:0];
      ram_wdata = wb_res;
    end
  end

  assign ram_re = cmd.op_read;

  pfx_ram #(
    .WIDTH (W),
    .DEPTH (pfx_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (below[AW-1:0]),
    .rdata (opnd_a)
  );

  pfx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (opnd_a),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (err != pfx_pkg::ST_OK) begin
      st_final = err;
    end else if (count == CW'(1)) begin
      st_final = pfx_pkg::ST_OK;
    end else begin
      st_final = pfx_pkg::ST_COUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= pfx_pkg::MODE_IDLE;
      acc   <= '0;
      err   <= pfx_pkg::ST_OK;
      count <= '0;
    end else if (cmd.take) begin
      if (!is_space) begin
        case (mode)
          pfx_pkg::MODE_IDLE: begin
            if (ch == pfx_pkg::CH_PLUS) begin
              mode <= pfx_pkg::MODE_OPER;
              op   <= pfx_pkg::OP_ADD;
            end else if (ch == pfx_pkg::CH_MINUS) begin
              mode <= pfx_pkg::MODE_OPER;
              op   <= pfx_pkg::OP_SUB;
            end else if (ch == pfx_pkg::CH_STAR) begin
              mode <= pfx_pkg::MODE_OPER;
              op   <= pfx_pkg::OP_MUL;
            end else if (ch == pfx_pkg::CH_SLASH) begin
              mode <= pfx_pkg::MODE_OPER;
              op   <= pfx_pkg::OP_DIV;
            end else if (is_digit) begin
              mode <= pfx_pkg::MODE_DIGITS;
              acc  <= digit_val;
            end else begin
              // bad token: note it, then skip the rest of it
              if (err == pfx_pkg::ST_OK) begin
                err <= pfx_pkg::ST_BADNUM;
              end
              mode <= pfx_pkg::MODE_TAIL;
              acc  <= '0;
            end
          end
          pfx_pkg::MODE_DIGITS: begin
            if (is_digit) begin
              acc <= acc_next;
            end else begin
              mode <= pfx_pkg::MODE_TAIL;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (cmd.finish) begin
      if ((mode == pfx_pkg::MODE_DIGITS || mode == pfx_pkg::MODE_TAIL) &&
          err == pfx_pkg::ST_OK) begin
        if (push_ok) begin
          tos   <= acc;
          count <= count + CW'(1);
        end else begin
          err <= pfx_pkg::ST_OVER;
        end
      end
      mode <= pfx_pkg::MODE_IDLE;
      acc  <= '0;
    end else if (cmd.op_fail) begin
      if (err == pfx_pkg::ST_OK) begin
        err <= pfx_pkg::ST_UNDER;
      end
      mode <= pfx_pkg::MODE_IDLE;
      acc  <= '0;
    end else if (cmd.op_read) begin
      mode <= pfx_pkg::MODE_IDLE;
      acc  <= '0;
    end else if (cmd.op_divz) begin
      err <= pfx_pkg::ST_DIVZ;
    end else if (cmd.op_arith || cmd.div_write) begin
      tos   <= wb_res;
      count <= count - CW'(1);
    end else if (cmd.emit) begin
      count <= '0;
      err   <= pfx_pkg::ST_OK;
      mode  <= pfx_pkg::MODE_IDLE;
      acc   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch   <= char_in;
      last <= end_of_expr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= st_final;
      value  <= (st_final == pfx_pkg::ST_OK) ? tos : '0;
    end
  end

  assign stat.last      = last;
  assign stat.space     = is_space;
  assign stat.mode_oper = (mode == pfx_pkg::MODE_OPER);
  assign stat.op_ok     = (err == pfx_pkg::ST_OK) && (count >= CW'(2));
  assign stat.op_div    = (op == pfx_pkg::OP_DIV);
  assign stat.b_zero    = (tos == '0);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(pfx_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0 && err == pfx_pkg::ST_OK && out_valid))
    else $error("state not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pfx_pkg::ST_OK) |-> (value == '0))
    else $error("non-zero value with error status");

  a_div_wb: assert property (@(posedge clk) disable iff (rst)
    cmd.div_write |-> (div_done && count >= CW'(2)))
    else $error("quotient written back without a finished divide");
`endif

endmodule

// File: sv/pfx_ctrl.sv
// Sequencer for character intake, token finish, operators and result hand-off.
module pfx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfx_pkg::stat_t stat,
  output pfx_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHAR = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_tok;

  assign in_stall  = (state != S_IDLE);
  assign after_tok = stat.last ? S_OUT : S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.take   = 1'b1;
        state_next = (stat.space || stat.last) ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!stat.mode_oper) begin
          cmd.finish = 1'b1;
          state_next = after_tok;
        end else if (!stat.op_ok) begin
          cmd.op_fail = 1'b1;
          state_next  = after_tok;
        end else begin
          cmd.op_read = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.op_div) begin
          cmd.op_arith = 1'b1;
          state_next   = after_tok;
        end else if (stat.b_zero) begin
          cmd.op_divz = 1'b1;
          state_next  = after_tok;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_write = 1'b1;
          state_next    = after_tok;
        end
      end
      S_OUT: begin
        // hold until the result register can take the new transaction
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIV))
    else $error("divide launched without waiting");

  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_OUT && stat.out_free))
    else $error("result loaded over a held result");
`endif

endmodule

// File: tb/sv/postfix_expression_evaluator_top_test.sv
// Self-checking testbench for the postfix expression evaluator top level.
module postfix_expression_evaluator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 60;

  typedef logic [7:0] char_q_t [$];

  typedef struct packed {
    logic signed [pfx_pkg::DATA_W-1:0] value;
    logic [2:0]                        status;
  } expr_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [7:0]                        char_in = '0;
  logic                              end_of_expr = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [pfx_pkg::DATA_W-1:0] value;
  logic [2:0]                        status;

  postfix_expression_evaluator_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .end_of_expr (end_of_expr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Evaluator state as the block should hold it
  logic [pfx_pkg::DATA_W-1:0] rpn_stack [pfx_pkg::STACK_DEPTH];
  int unsigned                rpn_depth = 0;
  logic [pfx_pkg::DATA_W-1:0] rpn_acc = '0;
  logic [1:0]                 rpn_mode = pfx_pkg::MODE_IDLE;
  logic [1:0]                 rpn_op = pfx_pkg::OP_ADD;
  logic [2:0]                 rpn_err = pfx_pkg::ST_OK;

  expr_result_t results_due [$];
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;
  int chars_sent = 0;
  int exprs_sent = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int status_seen [8];

  function void rpn_push(input logic [pfx_pkg::DATA_W-1:0] v);
    if (rpn_err != pfx_pkg::ST_OK) return;
    if (rpn_depth >= pfx_pkg::STACK_DEPTH) begin
      rpn_err = pfx_pkg::ST_OVER;
      return;
    end
    rpn_stack[rpn_depth] = v;
    rpn_depth++;
  endfunction

  function void rpn_apply(input logic [1:0] op);
    logic [pfx_pkg::DATA_W-1:0] a, b, r;
    longint qa, qb, q;
    if (rpn_err != pfx_pkg::ST_OK) return;
    if (rpn_depth < 2) begin
      rpn_err = pfx_pkg::ST_UNDER;
      return;
    end
    b = rpn_stack[rpn_depth-1];
    a = rpn_stack[rpn_depth-2];
    case (op)
      pfx_pkg::OP_ADD: r = a + b;
      pfx_pkg::OP_SUB: r = a - b;
      pfx_pkg::OP_MUL: r = a * b;
      default: begin
        if (b == '0) begin
          rpn_err = pfx_pkg::ST_DIVZ;
          return;
        end
        // divide wide so that the most negative over minus one wraps
        qa = $signed(a);
        qb = $signed(b);
        q = qa / qb;
        r = q[pfx_pkg::DATA_W-1:0];
      end
    endcase
    rpn_depth--;
    rpn_stack[rpn_depth-1] = r;
  endfunction

  function void rpn_close_token();
    if (rpn_mode == pfx_pkg::MODE_DIGITS || rpn_mode == pfx_pkg::MODE_TAIL) rpn_push(rpn_acc);
    else if (rpn_mode == pfx_pkg::MODE_OPER) rpn_apply(rpn_op);
    rpn_mode = pfx_pkg::MODE_IDLE;
    rpn_acc = '0;
    rpn_op = pfx_pkg::OP_ADD;
  endfunction

  function void rpn_eat_char(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE);
    if (c == pfx_pkg::CH_SPACE) begin
      rpn_close_token();
    end else if (rpn_mode == pfx_pkg::MODE_IDLE) begin
      case (c)
        pfx_pkg::CH_PLUS:  begin rpn_mode = pfx_pkg::MODE_OPER; rpn_op = pfx_pkg::OP_ADD; end
        pfx_pkg::CH_MINUS: begin rpn_mode = pfx_pkg::MODE_OPER; rpn_op = pfx_pkg::OP_SUB; end
        pfx_pkg::CH_STAR:  begin rpn_mode = pfx_pkg::MODE_OPER; rpn_op = pfx_pkg::OP_MUL; end
        pfx_pkg::CH_SLASH: begin rpn_mode = pfx_pkg::MODE_OPER; rpn_op = pfx_pkg::OP_DIV; end
        default: begin
          if (is_digit) begin
            rpn_mode = pfx_pkg::MODE_DIGITS;
            rpn_acc = 32'(c) - 32'(pfx_pkg::CH_ZERO);
          end else begin
            if (rpn_err == pfx_pkg::ST_OK) rpn_err = pfx_pkg::ST_BADNUM;
            rpn_mode = pfx_pkg::MODE_TAIL;
            rpn_acc = '0;
            rpn_op = pfx_pkg::OP_ADD;
          end
        end
      endcase
    end else if (rpn_mode == pfx_pkg::MODE_DIGITS) begin
      if (is_digit) rpn_acc = rpn_acc * 32'd10 + (32'(c) - 32'(pfx_pkg::CH_ZERO));
      else rpn_mode = pfx_pkg::MODE_TAIL;
    end
  endfunction

  function void rpn_step(input logic [7:0] c, input logic last, output logic got,
                         output expr_result_t res);
    res = '0;
    got = last;
    rpn_eat_char(c);
    if (last) begin
      rpn_close_token();
      res.status = rpn_err;
      if (rpn_err == pfx_pkg::ST_OK) begin
        if (rpn_depth == 1) res.value = rpn_stack[0];
        else res.status = pfx_pkg::ST_COUNT;
      end
      rpn_depth = 0;
      rpn_acc = '0;
      rpn_mode = pfx_pkg::MODE_IDLE;
      rpn_op = pfx_pkg::OP_ADD;
      rpn_err = pfx_pkg::ST_OK;
    end
  endfunction

  task report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_count++;
  endtask

  // Offer one character; returns at the edge that accepts it
  task automatic send_char(input logic [7:0] c, input logic last);
    logic got;
    expr_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_of_expr <= last;
    do @(posedge clk); while (in_stall);
    rpn_step(c, last, got, res);
    if (got) results_due.push_back(res);
    chars_sent++;
  endtask

  task automatic send_expr(input char_q_t text);
    if (text.size() == 0) text.push_back(pfx_pkg::CH_SPACE);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    exprs_sent++;
  endtask

  function automatic char_q_t from_string(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] any_but_space();
    logic [7:0] t;
    do t = 8'($urandom_range(255)); while (t == pfx_pkg::CH_SPACE);
    return t;
  endfunction

  function automatic char_q_t make_number();
    char_q_t q;
    string s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) s = "0";
    else if (pick < 12) s = "4294967295";
    else if (pick < 16) s = "2147483648";
    else if (pick < 19) s = "2147483647";
    else if (pick < 23) s = $sformatf("%0d%0d", $urandom, $urandom);
    else if (pick < 45) s = $sformatf("%0d", $urandom_range(9));
    else s = $sformatf("%0d", $urandom_range(999));
    q = from_string(s);
    if ($urandom_range(99) < 6) q.push_back(any_but_space());
    return q;
  endfunction

  function automatic char_q_t make_operator();
    char_q_t q;
    case ($urandom_range(4))
      0: q.push_back(pfx_pkg::CH_PLUS);
      1: q.push_back(pfx_pkg::CH_MINUS);
      2: q.push_back(pfx_pkg::CH_STAR);
      default: q.push_back(pfx_pkg::CH_SLASH);
    endcase
    if ($urandom_range(99) < 6) q.push_back(any_but_space());
    return q;
  endfunction

  // Balanced expression: every operator finds two operands, one value left
  function automatic char_q_t make_balanced(input int pushes, input int op_pct);
    char_q_t q, tok;
    int depth;
    int left;
    depth = 0;
    left = pushes;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(99) < op_pct)) begin
        tok = make_operator();
        depth--;
      end else begin
        tok = make_number();
        depth++;
        left--;
      end
      if (q.size() != 0) begin
        q.push_back(pfx_pkg::CH_SPACE);
        if ($urandom_range(99) < 10) q.push_back(pfx_pkg::CH_SPACE);
      end
      q = {q, tok};
    end
    if ($urandom_range(99) < 8) q.push_front(pfx_pkg::CH_SPACE);
    if ($urandom_range(99) < 8) q.push_back(pfx_pkg::CH_SPACE);
    return q;
  endfunction

  function automatic char_q_t make_expression();
    char_q_t q, tok;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      q = make_balanced($urandom_range(1, 4), 35);
    end else if (pick < 66) begin
      // near or past a full stack
      q = make_balanced($urandom_range(15, 18), 0);
    end else if (pick < 70) begin
      if ($urandom_range(1)) q = from_string("2147483648 4294967295 /");
      else q = from_string("2147483648 0 1- /");
    end else if (pick < 85) begin
      // unbalanced token runs
      for (int i = $urandom_range(1, 5); i > 0; i--) begin
        if ($urandom_range(1)) tok = make_number();
        else tok = make_operator();
        q = {q, tok};
        if (i > 1) q.push_back(pfx_pkg::CH_SPACE);
      end
    end else begin
      for (int i = $urandom_range(1, 6); i > 0; i--) q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  task test_directed();
    char_q_t q;
    send_expr(from_string("6 3/"));
    send_expr(from_string("7 0/"));
    send_expr(from_string("+"));
    send_expr(from_string("x"));
    send_expr(from_string(" "));
    send_expr(from_string("9a 2*"));
    send_expr(from_string("5 8-"));
    q = {8'hFF};
    send_expr(q);
    q = {8'h00};
    send_expr(q);
    send_expr(from_string("1 2"));
  endtask

  task test_random(input int n_chars, input int gap_pct, input int stall_pct);
    int first;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    first = chars_sent;
    while (chars_sent - first < n_chars) send_expr(make_expression());
  endtask

  // Receiver holds off while single-value expressions keep arriving
  task test_long_hold();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_seq++;
    for (int i = 0; i < 8; i++) send_expr(make_balanced($urandom_range(1, 2), 35));
  endtask

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    expr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      status_seen[status]++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d", value, status));
      end else begin
        want = results_due.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("result %0d value: got %0d want %0d",
                                    results_checked, value, want.value));
        if (status !== want.status)
          report_mismatch($sformatf("result %0d status: got %0d want %0d",
                                    results_checked, status, want.status));
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, results_due.size());
      $display("postfix_expression_evaluator_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 9;
    recv_stall_pct = 82;
    test_directed();
    test_random(200, 9, 82);
    test_random(200, 82, 9);
    test_long_hold();
    test_random(200, 0, 0);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    $display("Covered %0d characters in %0d expressions, %0d results checked",
             chars_sent, exprs_sent, results_checked);
    $display("Status mix ok/count/under/divz/badnum/over: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[pfx_pkg::ST_OK], status_seen[pfx_pkg::ST_COUNT],
             status_seen[pfx_pkg::ST_UNDER], status_seen[pfx_pkg::ST_DIVZ],
             status_seen[pfx_pkg::ST_BADNUM], status_seen[pfx_pkg::ST_OVER]);
    if (err_count == 0) begin
      $display("postfix_expression_evaluator_top_test: done, clean");
    end else begin
      $display("postfix_expression_evaluator_top_test: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pfx_pkg.sv
sv/pfx_ram.sv
sv/pfx_div.sv
sv/pfx_datapath.sv
sv/pfx_ctrl.sv
sv/postfix_expression_evaluator_top.sv
tb/sv/postfix_expression_evaluator_top_test.sv
